@@ sv/mije_pkg.sv @@
// Shared constants, opcodes and stage structures of the MIPS immediate and jump execute block.
`default_nettype none
package mije_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int DMEM_AW    = $clog2(DATA_WORDS);

  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;

  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef enum logic [3:0] {
    MOP_NONE = 4'd0,
    MOP_LB   = 4'd1,
    MOP_LBU  = 4'd2,
    MOP_LH   = 4'd3,
    MOP_LHU  = 4'd4,
    MOP_LW   = 4'd5,
    MOP_SB   = 4'd6,
    MOP_SH   = 4'd7,
    MOP_SW   = 4'd8
  } mop_t;

  typedef struct packed {
    logic        recognized;
    logic        rw;
    logic [4:0]  rd;
    logic [31:0] rv;
    logic [31:0] npc;
    mop_t        mop;
    logic [29:0] waddr;
    logic [1:0]  boff;
    logic [31:0] sdata;
  } ex_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [29:0] mem_word_address;
    logic [31:0] mem_data;
    logic        recognized;
  } res_t;

  typedef struct packed {
    logic        vld;
    logic [4:0]  idx;
    logic [31:0] val;
  } fwd_t;

endpackage
`default_nettype wire

@@ sv/mije_regfile.sv @@
// General register file: one write port, two registered read ports with write bypass.
`default_nettype none
module mije_regfile (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        ren,
  input  wire logic [4:0]  raddr_a,
  input  wire logic [4:0]  raddr_b,
  output logic      [31:0] rdata_a,
  output logic      [31:0] rdata_b,
  input  wire logic        we,
  input  wire logic [4:0]  waddr,
  input  wire logic [31:0] wdata
);

  logic [31:0] mem [32];
  logic [31:0] vld_r;
  logic [31:0] rdata_a_r;
  logic [31:0] rdata_b_r;

  // An entry not yet written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_a_r <= (we && waddr == raddr_a) ? wdata :
                   (vld_r[raddr_a] ? mem[raddr_a] : 32'd0);
      rdata_b_r <= (we && waddr == raddr_b) ? wdata :
                   (vld_r[raddr_b] ? mem[raddr_b] : 32'd0);
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

@@ sv/mije_dmem.sv @@
// Data memory with a clearing pass after reset and a registered, write-bypassed read port.
`default_nettype none
module mije_dmem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  output logic                             busy,
  input  wire logic                        ren,
  input  wire logic [mije_pkg::DMEM_AW-1:0] raddr,
  output logic      [31:0]                 rdata,
  input  wire logic                        we,
  input  wire logic [mije_pkg::DMEM_AW-1:0] waddr,
  input  wire logic [31:0]                 wdata
);

  logic [31:0]                 mem [mije_pkg::DATA_WORDS];
  logic                        clr_busy_r;
  logic [mije_pkg::DMEM_AW-1:0] clr_idx_r;
  logic [31:0]                 rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == mije_pkg::DMEM_AW'(mije_pkg::DATA_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= 32'd0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_r <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

  assign busy  = clr_busy_r;
  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/mije_execute.sv @@
// Decode and execute stage: operand forwarding, ALU, branch and jump targets, memory address.
`default_nettype none
module mije_execute (
  input  wire logic [31:0]     ins,
  input  wire logic [31:0]     pc,
  input  wire logic [31:0]     a_raw,
  input  wire logic [31:0]     b_raw,
  input  wire mije_pkg::fwd_t  fwd,
  output mije_pkg::ex_t        ex
);

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] pc4;
  logic [31:0] addr;
  logic [31:0] btarget;
  logic [31:0] jtarget;
  logic        rw;

  assign op      = ins[31:26];
  assign rs      = ins[25:21];
  assign rt      = ins[20:16];
  assign imm     = {16'd0, ins[15:0]};
  assign simm    = {{16{ins[15]}}, ins[15:0]};
  assign a       = (fwd.vld && fwd.idx == rs) ? fwd.val : a_raw;
  assign b       = (fwd.vld && fwd.idx == rt) ? fwd.val : b_raw;
  assign pc4     = pc + 32'd4;
  assign addr    = a + simm;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign jtarget = {pc[31:28], ins[25:0], 2'b00};

  always_comb begin
    ex            = '0;
    ex.recognized = 1'b1;
    ex.rd         = rt;
    ex.npc        = pc4;
    ex.mop        = mije_pkg::MOP_NONE;
    ex.waddr      = addr[31:2];
    ex.boff       = addr[1:0];
    ex.sdata      = b;
    rw            = 1'b0;
    case (op)
      mije_pkg::OP_ADDI, mije_pkg::OP_ADDIU: begin
        rw    = 1'b1;
        ex.rv = addr;
      end
      mije_pkg::OP_SLTI: begin
        rw    = 1'b1;
        ex.rv = {31'd0, $signed(a) < $signed(simm)};
      end
      mije_pkg::OP_SLTIU: begin
        rw    = 1'b1;
        ex.rv = {31'd0, a < simm};
      end
      mije_pkg::OP_ANDI: begin
        rw    = 1'b1;
        ex.rv = a & imm;
      end
      mije_pkg::OP_XORI: begin
        rw    = 1'b1;
        ex.rv = a ^ imm;
      end
      mije_pkg::OP_LUI: begin
        rw    = 1'b1;
        ex.rv = {ins[15:0], 16'd0};
      end
      mije_pkg::OP_BEQ: begin
        if (a == b) ex.npc = btarget;
      end
      mije_pkg::OP_BNE: begin
        if (a != b) ex.npc = btarget;
      end
      mije_pkg::OP_BLEZ: begin
        if (a == 32'd0 || a[31]) ex.npc = btarget;
      end
      mije_pkg::OP_BGTZ: begin
        if (a != 32'd0 && !a[31]) ex.npc = btarget;
      end
      mije_pkg::OP_J: begin
        ex.npc = jtarget;
      end
      mije_pkg::OP_JAL: begin
        ex.npc = jtarget;
        rw     = 1'b1;
        ex.rd  = mije_pkg::LINK_REG;
        ex.rv  = pc4;
      end
      mije_pkg::OP_LB: begin
        rw     = 1'b1;
        ex.mop = mije_pkg::MOP_LB;
      end
      mije_pkg::OP_LBU: begin
        rw     = 1'b1;
        ex.mop = mije_pkg::MOP_LBU;
      end
      mije_pkg::OP_LH: begin
        rw     = 1'b1;
        ex.mop = mije_pkg::MOP_LH;
      end
      mije_pkg::OP_LHU: begin
        rw     = 1'b1;
        ex.mop = mije_pkg::MOP_LHU;
      end
      mije_pkg::OP_LW: begin
        rw     = 1'b1;
        ex.mop = mije_pkg::MOP_LW;
      end
      mije_pkg::OP_SB: begin
        ex.mop = mije_pkg::MOP_SB;
      end
      mije_pkg::OP_SH: begin
        ex.mop = mije_pkg::MOP_SH;
      end
      mije_pkg::OP_SW: begin
        ex.mop = mije_pkg::MOP_SW;
      end
      default: begin
        ex.recognized = 1'b0;
        ex.npc        = pc;
      end
    endcase
    // Writes to register zero are dropped.
    ex.rw = rw && (ex.rd != 5'd0);
  end

endmodule
`default_nettype wire

@@ sv/mije_lsu.sv @@
// Load extraction and store merge stage, forming the final result fields.
`default_nettype none
module mije_lsu (
  input  wire mije_pkg::ex_t  ex,
  input  wire logic [31:0]    word,
  output mije_pkg::res_t      res
);

  logic [4:0]  bsh;
  logic [4:0]  hsh;
  logic [7:0]  lbyte;
  logic [15:0] lhalf;
  logic [31:0] bmask;
  logic [31:0] hmask;
  logic [31:0] value;
  logic [31:0] mdata;
  logic        mw;

  assign bsh   = {ex.boff, 3'b000};
  assign hsh   = {ex.boff[1], 4'b0000};
  assign lbyte = 8'(word >> bsh);
  assign lhalf = 16'(word >> hsh);
  assign bmask = 32'h0000_00FF << bsh;
  assign hmask = 32'h0000_FFFF << hsh;

  always_comb begin
    value = ex.rv;
    mdata = 32'd0;
    mw    = 1'b0;
    case (ex.mop)
      mije_pkg::MOP_LB:  value = {{24{lbyte[7]}}, lbyte};
      mije_pkg::MOP_LBU: value = {24'd0, lbyte};
      mije_pkg::MOP_LH:  value = {{16{lhalf[15]}}, lhalf};
      mije_pkg::MOP_LHU: value = {16'd0, lhalf};
      mije_pkg::MOP_LW:  value = word;
      mije_pkg::MOP_SB: begin
        mw    = 1'b1;
        mdata = (word & ~bmask) | ({24'd0, ex.sdata[7:0]} << bsh);
      end
      mije_pkg::MOP_SH: begin
        mw    = 1'b1;
        mdata = (word & ~hmask) | ({16'd0, ex.sdata[15:0]} << hsh);
      end
      mije_pkg::MOP_SW: begin
        mw    = 1'b1;
        mdata = ex.sdata;
      end
      default: value = ex.rv;
    endcase
  end

  always_comb begin
    res                  = '0;
    res.next_pc          = ex.npc;
    res.recognized       = ex.recognized;
    res.reg_write        = ex.rw;
    res.reg_index        = ex.rw ? ex.rd : 5'd0;
    res.reg_value        = ex.rw ? value : 32'd0;
    res.mem_write        = mw;
    res.mem_word_address = mw ? ex.waddr : 30'd0;
    res.mem_data         = mdata;
  end

endmodule
`default_nettype wire

@@ sv/mips_immediate_jump_execute.sv @@
// Top level of the MIPS immediate and jump execute block: pipeline registers and handshakes.
//
//   channel  direction  beat contents (low bits first)
//   in_      slave      instruction[31:0]
//   out_     master     next_pc, reg_write, reg_index, reg_value, mem_write,
//                       mem_word_address, mem_data, recognized, two zero bits
//   cfg_     write      start_pc, loaded straight into the program counter
//
// One beat is taken per cycle unless the output stalls with the input register full or the
// data memory is cleared; out_tvalid follows the register read on acceptance, then execute
// with data memory read, then load extraction or store merge.
// Forwarding from the merge stage and write bypass in both memories keep that rate.
// After reset all DATA_WORDS data memory words are cleared with in_tready low.
// A stalled output beat holds the whole pipeline; the input register still fills if empty.
`default_nettype none
module mips_immediate_jump_execute (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // instruction[31:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // next_pc[31:0], reg_write[32], reg_index[37:33], reg_value[69:38], mem_write[70],
  // mem_word_address[100:71], mem_data[132:101], recognized[133], zero[135:134]
  output logic      [135:0] out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);

  logic                        en;
  logic                        ld1;
  logic                        clr_busy;
  logic                        s1_vld_r;
  logic                        s1_vld_nxt;
  logic [31:0]                 ins_r;
  logic [31:0]                 pc_r;
  logic [31:0]                 a_raw;
  logic [31:0]                 b_raw;
  mije_pkg::fwd_t              fwd;
  mije_pkg::ex_t               ex;
  logic                        s2_vld_r;
  mije_pkg::ex_t               s2_ex_r;
  logic [31:0]                 mem_word;
  mije_pkg::res_t              res;
  logic                        out_vld_r;
  mije_pkg::res_t              out_res_r;
  logic                        rf_we;
  logic                        dm_we;

  assign en         = !out_vld_r || out_tready;
  assign in_tready  = !clr_busy && (en || !s1_vld_r);
  assign ld1        = in_tvalid && in_tready;
  assign s1_vld_nxt = ld1 ? 1'b1 : (en ? 1'b0 : s1_vld_r);
  assign rf_we      = en && s2_vld_r && res.reg_write;
  assign dm_we      = en && s2_vld_r && res.mem_write;

  assign fwd.vld = s2_vld_r && res.reg_write;
  assign fwd.idx = res.reg_index;
  assign fwd.val = res.reg_value;

  mije_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ren     (ld1),
    .raddr_a (in_tdata[25:21]),
    .raddr_b (in_tdata[20:16]),
    .rdata_a (a_raw),
    .rdata_b (b_raw),
    .we      (rf_we),
    .waddr   (res.reg_index),
    .wdata   (res.reg_value)
  );

  mije_execute u_execute (
    .ins   (ins_r),
    .pc    (pc_r),
    .a_raw (a_raw),
    .b_raw (b_raw),
    .fwd   (fwd),
    .ex    (ex)
  );

  mije_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .ren   (en),
    .raddr (ex.waddr[mije_pkg::DMEM_AW-1:0]),
    .rdata (mem_word),
    .we    (dm_we),
    .waddr (res.mem_word_address[mije_pkg::DMEM_AW-1:0]),
    .wdata (res.mem_data)
  );

  mije_lsu u_lsu (
    .ex   (s2_ex_r),
    .word (mem_word),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= mije_pkg::START_PC_RESET;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (en) begin
        s2_vld_r  <= s1_vld_r;
        out_vld_r <= s2_vld_r;
      end
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end else if (en && s1_vld_r) begin
        pc_r <= ex.npc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      ins_r <= in_tdata;
    end
    if (en) begin
      s2_ex_r   <= ex;
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00,
                       out_res_r.recognized,
                       out_res_r.mem_data,
                       out_res_r.mem_word_address,
                       out_res_r.mem_write,
                       out_res_r.reg_value,
                       out_res_r.reg_index,
                       out_res_r.reg_write,
                       out_res_r.next_pc};

endmodule
`default_nettype wire

@@ sv/mije_checker.sv @@
// Port-level checker for the execute block, bound to its top level.
`default_nettype none
module mije_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_no_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[37:33] != 5'd0)
    else $error("register zero reported as written");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[133] |-> !out_tdata[32] && !out_tdata[70])
    else $error("unrecognised instruction caused a write");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[70]))
    else $error("register and memory written by one beat");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("input ready during memory clearing");

endmodule

bind mips_immediate_jump_execute mije_checker u_mije_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata)
);
`default_nettype wire
